[design/tsvs_pkg.sv]
// ----------------------------------------------------------------------------
// tsvs_pkg
// Shared constants and types of the tree sieve victim select unit: cache
// geometry, state entry layout and request kinds.
// ----------------------------------------------------------------------------
package tsvs_pkg;

   // cache geometry
   localparam int WAYS = 8;
   localparam int SETS = 64;

   // cursor tree: heap ordered, node n has children 2n+1 and 2n+2
   localparam int NODES  = (WAYS > 2) ? (WAYS / 2 - 1) : 0;
   localparam int NODE_W = (NODES > 0) ? NODES : 1;

   // tree walk index covers nodes and leaves (0 .. 2*NODES)
   localparam int IDX_W     = (NODES > 0) ? $clog2(2 * NODES + 1) : 1;
   localparam int CUR_EXT_W = 1 << IDX_W;
   localparam int DEPTH     = (NODES > 0) ? $clog2(NODES + 1) : 1;

   // way indexing inside the state entry
   localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int STALE_W = 1 << WAY_W;

   // set addressing
   localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;

   // item field widths
   localparam int KIND_W     = 2;
   localparam int SET_FLD_W  = 6;
   localparam int WAY_FLD_W  = 3;
   localparam int VICTIM_W   = 3;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 8;

   // state entry: stale bits low, cursor bits high
   localparam int ENTRY_W = WAYS + NODE_W;
   localparam logic [ENTRY_W-1:0] ENTRY_RESET = {{NODE_W{1'b0}}, {WAYS{1'b1}}};

   typedef enum logic [KIND_W-1:0] {
      REQ_HIT        = 2'd0,
      REQ_INVALIDATE = 2'd1,
      REQ_FILL       = 2'd2,
      REQ_VICTIM     = 2'd3
   } req_kind_type;

endpackage

[design/tsvs_ram.sv]
// ----------------------------------------------------------------------------
// tsvs_ram
// Generic single write port, single read port RAM with registered read data.
// Read data holds when no read is issued.
// ----------------------------------------------------------------------------
module tsvs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/tree_sieve_victim_select_unit.sv]
// ----------------------------------------------------------------------------
// tree_sieve_victim_select_unit
// Cache replacement state: stale bit per way and cursor tree per set, with
// victim selection by walking the cursor tree down to a pair of ways.
// ----------------------------------------------------------------------------
// One item is taken per cycle while results drain; every item gives exactly
// one result, which passes from the update stage into the output register.
// The per-set state (stale bits and cursor bits) sits in a single state RAM:
// the set is read at the accepting edge, updated in the update stage and
// written back at the edge that hands the result to the output register.
// A write to the same set at the read edge is bypassed into the update.
// A valid bit per set stands in for the reset contents (all lines stale,
// cursor at zero), so the block is ready straight after reset with no
// clearing pass. The output register frees the update stage, so a stalled
// result holds back at most one further item.
// ----------------------------------------------------------------------------
module tree_sieve_victim_select_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // set_index[5:0], way[8:6], random_bit[9], zero pad
   input  logic [tsvs_pkg::REQ_DATA_W-1:0]   req_tdata,
   // req_type[1:0]
   input  logic [tsvs_pkg::KIND_W-1:0]       req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // victim_way[2:0], zero pad
   output logic [tsvs_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // victim_valid[0]
   output logic                              rsp_tuser
);

   // request fields
   logic [tsvs_pkg::SET_W-1:0]     req_set;
   logic [tsvs_pkg::WAY_FLD_W-1:0] req_way;
   logic                           req_rnd;
   logic                           req_accept;

   // update stage
   logic                           s1_valid_ff, s1_valid_in;
   tsvs_pkg::req_kind_type         s1_kind_ff;
   logic [tsvs_pkg::SET_W-1:0]     s1_set_ff;
   logic [tsvs_pkg::WAY_FLD_W-1:0] s1_way_ff;
   logic                           s1_rnd_ff;
   logic                           s1_init_ff;
   logic                           s1_fwd_ff;
   logic [tsvs_pkg::ENTRY_W-1:0]   fwd_data_ff;
   logic                           s1_adv;

   // per-set valid bits
   logic [tsvs_pkg::SETS-1:0]      set_valid_ff;

   // output register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [tsvs_pkg::VICTIM_W-1:0]  rsp_way_ff;
   logic                           rsp_victim_ff;

   // state RAM
   logic [tsvs_pkg::ENTRY_W-1:0]   ram_rd_data;
   logic [tsvs_pkg::ENTRY_W-1:0]   new_entry;

   // update logic
   logic [tsvs_pkg::ENTRY_W-1:0]   entry;
   logic [tsvs_pkg::STALE_W-1:0]   stale_ext;
   logic [tsvs_pkg::STALE_W-1:0]   new_stale;
   logic [tsvs_pkg::CUR_EXT_W-1:0] cur_ext;
   logic [tsvs_pkg::CUR_EXT_W-1:0] new_cur;
   logic [tsvs_pkg::WAY_W-1:0]     way_idx;
   logic                           way_ok;
   logic [tsvs_pkg::VICTIM_W-1:0]  victim;

   assign req_set = tsvs_pkg::SET_W'(req_tdata[tsvs_pkg::SET_FLD_W-1:0]);
   assign req_way = req_tdata[tsvs_pkg::SET_FLD_W +: tsvs_pkg::WAY_FLD_W];
   assign req_rnd = req_tdata[tsvs_pkg::SET_FLD_W + tsvs_pkg::WAY_FLD_W];

   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign req_accept = req_tvalid && req_tready;

   assign s1_valid_in  = req_accept || (s1_valid_ff && !s1_adv);
   assign rsp_valid_in = s1_adv || (rsp_valid_ff && !rsp_tready);

   tsvs_ram #(
      .WIDTH (tsvs_pkg::ENTRY_W),
      .DEPTH (tsvs_pkg::SETS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_set_ff),
      .wr_data (new_entry),
      .rd_en   (req_accept),
      .rd_addr (req_set),
      .rd_data (ram_rd_data)
   );

   // entry as seen by the item in the update stage
   always_comb begin
      if (s1_fwd_ff) begin
         entry = fwd_data_ff;
      end else if (s1_init_ff) begin
         entry = tsvs_pkg::ENTRY_RESET;
      end else begin
         entry = ram_rd_data;
      end
      stale_ext = tsvs_pkg::STALE_W'(entry[tsvs_pkg::WAYS-1:0]);
      cur_ext   = tsvs_pkg::CUR_EXT_W'(entry[tsvs_pkg::ENTRY_W-1:tsvs_pkg::WAYS]);
      way_ok    = 32'(s1_way_ff) < tsvs_pkg::WAYS;
      way_idx   = tsvs_pkg::WAY_W'(s1_way_ff);
   end

   // victim pick and cursor advance
   always_comb begin
      logic [tsvs_pkg::IDX_W-1:0] idx;
      logic [tsvs_pkg::WAY_W-1:0] left;
      logic [tsvs_pkg::WAY_W-1:0] right;
      logic [tsvs_pkg::WAY_W-1:0] pick;
      logic                       ls;
      logic                       rs;
      logic                       go_right;
      logic                       advance;
      logic                       done;
      logic                       was_right;

      idx       = '0;
      left      = '0;
      right     = '0;
      pick      = '0;
      ls        = 1'b0;
      rs        = 1'b0;
      go_right  = 1'b0;
      advance   = 1'b0;
      done      = 1'b0;
      was_right = 1'b0;
      new_cur   = cur_ext;

      if (tsvs_pkg::WAYS > 2) begin
         // walk down, bit set goes right
         for (int d = 0; d < tsvs_pkg::DEPTH; d++) begin
            if (32'(idx) < tsvs_pkg::NODES) begin
               idx = tsvs_pkg::IDX_W'({idx, 1'b0} + 1 + cur_ext[idx]);
            end
         end
         left  = tsvs_pkg::WAY_W'(2 * (32'(idx) - tsvs_pkg::NODES));
         right = left | tsvs_pkg::WAY_W'(1);
         ls    = stale_ext[left];
         rs    = stale_ext[right];
         if (ls != rs) begin
            go_right = rs;
            advance  = 1'b1;
         end else begin
            go_right = s1_rnd_ff;
            advance  = !ls;
         end
         pick = go_right ? right : left;
         if (32'(pick) >= tsvs_pkg::WAYS) begin
            pick = left;
         end
         // binary increment upward: right children clear, first left child sets
         for (int d = 0; d < tsvs_pkg::DEPTH; d++) begin
            if (advance && !done && idx != '0) begin
               was_right = !idx[0];
               idx       = (idx - tsvs_pkg::IDX_W'(1)) >> 1;
               if (was_right) begin
                  new_cur[idx] = 1'b0;
               end else begin
                  new_cur[idx] = 1'b1;
                  done         = 1'b1;
               end
            end
         end
      end else if (tsvs_pkg::WAYS == 2) begin
         ls = stale_ext[0];
         rs = stale_ext[1];
         if (ls == rs) begin
            pick = tsvs_pkg::WAY_W'(s1_rnd_ff);
         end else begin
            pick = ls ? tsvs_pkg::WAY_W'(0) : tsvs_pkg::WAY_W'(1);
         end
      end
      victim = tsvs_pkg::VICTIM_W'(pick);
   end

   // entry write-back
   always_comb begin
      new_stale = stale_ext;
      case (s1_kind_ff)
         tsvs_pkg::REQ_HIT: begin
            if (way_ok) new_stale[way_idx] = 1'b0;
         end
         tsvs_pkg::REQ_INVALIDATE, tsvs_pkg::REQ_FILL: begin
            if (way_ok) new_stale[way_idx] = 1'b1;
         end
         default: begin
         end
      endcase
      if (s1_kind_ff == tsvs_pkg::REQ_VICTIM) begin
         new_entry = {new_cur[tsvs_pkg::NODE_W-1:0], stale_ext[tsvs_pkg::WAYS-1:0]};
      end else begin
         new_entry = {cur_ext[tsvs_pkg::NODE_W-1:0], new_stale[tsvs_pkg::WAYS-1:0]};
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         set_valid_ff <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_adv) begin
            set_valid_ff[s1_set_ff] <= 1'b1;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_kind_ff  <= tsvs_pkg::req_kind_type'(req_tuser);
         s1_set_ff   <= req_set;
         s1_way_ff   <= req_way;
         s1_rnd_ff   <= req_rnd;
         s1_init_ff  <= !set_valid_ff[req_set];
         // same set written at this edge: the RAM read returns the old entry
         s1_fwd_ff   <= s1_adv && (s1_set_ff == req_set);
         fwd_data_ff <= new_entry;
      end
      if (s1_adv) begin
         rsp_victim_ff <= (s1_kind_ff == tsvs_pkg::REQ_VICTIM);
         rsp_way_ff    <= (s1_kind_ff == tsvs_pkg::REQ_VICTIM) ? victim : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = tsvs_pkg::RSP_DATA_W'(rsp_way_ff);
   assign rsp_tuser  = rsp_victim_ff;

`ifndef NO_ASSERTIONS
   a_non_victim_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_victim_ff |-> rsp_way_ff == '0)
      else $error("non-victim result carries a way");

   a_written_set_valid: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> set_valid_ff[$past(s1_set_ff)])
      else $error("written set not marked valid");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !s1_valid_ff && !rsp_valid_ff && set_valid_ff == '0)
      else $error("pipeline or valid bits not cleared by reset");

   a_stall_holds_stage: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_valid_ff && !rsp_tready |=> s1_valid_ff && $stable(s1_set_ff))
      else $error("update stage lost its item under stall");
`endif

endmodule
